### src/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg: shared types and constants for the line-start table search
// Command codes, fixed field widths and the control bundle that the
// sequencer sends to every search cell.
// ----------------------------------------------------------------------------
`default_nettype none

package lst_pkg;

   // request field widths fixed by the interface
   localparam int CMD_W      = 2;
   localparam int ENTRY_IN_W = 10;
   localparam int COUNT_IN_W = 11;
   localparam int LINE_W     = 10;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   // per-cycle control broadcast to all cells
   typedef struct packed {
      logic clear;     // drop the hit held from the previous lookup
      logic rd_valid;  // read data in the cells belongs to the current scan
   } lst_ctrl_type;

endpackage

`default_nettype wire

### src/lst_cell.sv
// ----------------------------------------------------------------------------
// lst_cell: one bank of the line-start table and its search slice
// Holds a bank of entries, scans it from the top address down during a
// lookup, keeps the highest qualifying address and merges it into the
// result token passed up the chain every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_cell #(
   parameter int ID_WIDTH = 32,
   parameter int BANK_AW  = 5,
   parameter int IDX_W    = 10,
   parameter int CNT_W    = 11,
   parameter int CELL_NUM = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lst_pkg::lst_ctrl_type ctrl_in,
   input  wire logic                  wr_en,
   input  wire logic [BANK_AW-1:0]    wr_addr,
   input  wire logic [ID_WIDTH-1:0]   wr_identifier,
   input  wire logic                  wr_continues,
   input  wire logic [BANK_AW-1:0]    rd_addr,
   input  wire logic [ID_WIDTH-1:0]   target,
   input  wire logic [CNT_W-1:0]      count,
   input  wire logic                  up_hit,
   input  wire logic [IDX_W-1:0]      up_index,
   output logic                       tok_hit,
   output logic [IDX_W-1:0]           tok_index
);
   import lst_pkg::*;

   localparam int BANK_DEPTH = 2 ** BANK_AW;

   logic [ID_WIDTH:0]    mem [BANK_DEPTH];
   logic [ID_WIDTH:0]    rd_data_ff;
   logic [BANK_AW-1:0]   rd_addr_ff;
   logic [ID_WIDTH-1:0]  rd_id;
   logic                 rd_cont;
   logic [IDX_W-1:0]     rd_global;
   logic [IDX_W-1:0]     own_global;
   logic                 in_count;
   logic                 qualify;
   logic                 hit_ff, hit_in;
   logic [BANK_AW-1:0]   own_addr_ff, own_addr_in;
   logic                 tok_hit_ff, tok_hit_in;
   logic [IDX_W-1:0]     tok_index_ff, tok_index_in;

   // bank memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_continues, wr_identifier};
      end
      rd_data_ff <= mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   // table position of the entry just read
   assign rd_global  = (IDX_W'(CELL_NUM) << BANK_AW) | IDX_W'(rd_addr_ff);
   assign own_global = (IDX_W'(CELL_NUM) << BANK_AW) | IDX_W'(own_addr_ff);
   assign rd_id      = rd_data_ff[ID_WIDTH-1:0];
   assign rd_cont    = rd_data_ff[ID_WIDTH];

   // within the entry count and below the target, or equal to it and not a continuation line
   assign in_count = {1'b0, rd_global} < (IDX_W+1)'(count);
   assign qualify  = ctrl_in.rd_valid && in_count &&
                     ((rd_id < target) || ((rd_id == target) && !rd_cont));

   // scan runs downward: the first hit is this bank's highest one
   always_comb begin
      hit_in      = hit_ff;
      own_addr_in = own_addr_ff;
      if (ctrl_in.clear) begin
         hit_in = 1'b0;
      end else if (qualify && !hit_ff) begin
         hit_in      = 1'b1;
         own_addr_in = rd_addr_ff;
      end
   end

   // token from the lower banks loses to a hit in this bank
   always_comb begin
      if (hit_ff) begin
         tok_hit_in   = 1'b1;
         tok_index_in = own_global;
      end else begin
         tok_hit_in   = up_hit;
         tok_index_in = up_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff     <= 1'b0;
         tok_hit_ff <= 1'b0;
      end else begin
         hit_ff     <= hit_in;
         tok_hit_ff <= tok_hit_in;
      end
      own_addr_ff  <= own_addr_in;
      tok_index_ff <= tok_index_in;
   end

   assign tok_hit   = tok_hit_ff;
   assign tok_index = tok_index_ff;

endmodule

`default_nettype wire

### src/line_start_table_search.sv
// ----------------------------------------------------------------------------
// line_start_table_search: greatest qualifying line-start entry lookup
// The table is split across a chain of cells, each owning one bank of
// entries. A lookup scans all banks in parallel from the top address down,
// then the per-bank hits ripple up the chain to give the greatest index.
// ----------------------------------------------------------------------------
// Write and set-count requests give no response and may be issued back to
// back. A lookup holds busy through its bank scan and chain drain states,
// and its response strobe rises in the same cycle that busy falls. The
// default 1024 entries are split into 32 banks of 32; the bank scan does
// one read per cycle in every bank, and the result chain adds one register
// per cell. The receiver cannot stall; each response is shown for one
// cycle.
// Synchronous reset clears the entry count and the sequencer; table contents
// stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module line_start_table_search #(
   parameter int TABLE_DEPTH = 1024,
   parameter int ID_WIDTH    = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [lst_pkg::CMD_W-1:0]       req_command,
   input  wire logic [lst_pkg::ENTRY_IN_W-1:0]  req_entry_index,
   input  wire logic [ID_WIDTH-1:0]             req_entry_identifier,
   input  wire logic                            req_entry_continues,
   input  wire logic [lst_pkg::COUNT_IN_W-1:0]  req_entry_count,
   input  wire logic [ID_WIDTH-1:0]             req_target_identifier,
   output logic                                 rsp_strobe,
   output logic [lst_pkg::LINE_W-1:0]           rsp_line_index,
   output logic                                 rsp_found
);
   import lst_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int CELL_AW = (IDX_W > 5) ? 5 : IDX_W - 1;
   localparam int BANK_AW = IDX_W - CELL_AW;
   localparam int CELLS   = 2 ** CELL_AW;
   localparam int DRN_W   = CELL_AW + 2;
   localparam int EXT_W   = (IDX_W > ENTRY_IN_W) ? IDX_W : ENTRY_IN_W;
   localparam int CW      = (CNT_W > COUNT_IN_W) ? CNT_W : COUNT_IN_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [BANK_AW-1:0]  scan_addr_ff, scan_addr_in;
   logic [DRN_W-1:0]    drain_ff, drain_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [ID_WIDTH-1:0] target_ff, target_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                strobe_ff, strobe_in;
   logic [LINE_W-1:0]   line_ff, line_in;
   logic                found_ff, found_in;

   logic                accept;
   logic                do_write;
   logic                do_lookup;
   logic [EXT_W-1:0]    ent_ext;
   logic                ent_in_range;
   logic [IDX_W-1:0]    wr_idx;
   logic [CW-1:0]       cnt_ext;
   lst_ctrl_type        ctrl;

   logic                chain_hit   [CELLS];
   logic [IDX_W-1:0]    chain_index [CELLS];

   // request decode
   assign accept       = start && !busy;
   assign do_write     = accept && (req_command == CMD_WRITE) && ent_in_range;
   assign do_lookup    = accept && (req_command == CMD_LOOKUP);
   assign ent_ext      = EXT_W'(req_entry_index);
   assign ent_in_range = {1'b0, ent_ext} < (EXT_W+1)'(TABLE_DEPTH);
   assign wr_idx       = ent_ext[IDX_W-1:0];
   assign cnt_ext      = CW'(req_entry_count);

   assign ctrl.clear    = do_lookup;
   assign ctrl.rd_valid = rd_valid_ff;

   // entry count, saturated at the table depth
   always_comb begin
      count_in = count_ff;
      if (accept && (req_command == CMD_COUNT)) begin
         if (cnt_ext > CW'(TABLE_DEPTH)) begin
            count_in = CNT_W'(TABLE_DEPTH);
         end else begin
            count_in = CNT_W'(cnt_ext);
         end
      end
   end

   // lookup sequencer: bank scan, then chain drain, then response
   always_comb begin
      state_in     = state_ff;
      scan_addr_in = scan_addr_ff;
      drain_in     = drain_ff;
      target_in    = target_ff;
      strobe_in    = 1'b0;
      line_in      = line_ff;
      found_in     = found_ff;
      rd_valid_in  = (state_ff == ST_SCAN);
      unique case (state_ff)
         ST_IDLE: begin
            if (do_lookup) begin
               target_in    = req_target_identifier;
               scan_addr_in = {BANK_AW{1'b1}};
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_addr_in = scan_addr_ff - 1'b1;
            if (scan_addr_ff == '0) begin
               drain_in = DRN_W'(CELLS + 1);
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff - 1'b1;
            if (drain_ff == '0) begin
               strobe_in = 1'b1;
               line_in   = LINE_W'(chain_index[CELLS-1]);
               found_in  = chain_hit[CELLS-1];
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
         strobe_ff   <= strobe_in;
         count_ff    <= count_in;
      end
      scan_addr_ff <= scan_addr_in;
      drain_ff     <= drain_in;
      target_ff    <= target_in;
      line_ff      <= line_in;
      found_ff     <= found_in;
   end

   // chain of bank cells; the token enters at cell 0 empty
   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      logic             up_hit;
      logic [IDX_W-1:0] up_index;
      logic             wr_sel;

      if (k == 0) begin : g_first
         assign up_hit   = 1'b0;
         assign up_index = '0;
      end else begin : g_next
         assign up_hit   = chain_hit[k-1];
         assign up_index = chain_index[k-1];
      end

      assign wr_sel = do_write && ((wr_idx >> BANK_AW) == IDX_W'(k));

      lst_cell #(
         .ID_WIDTH (ID_WIDTH),
         .BANK_AW  (BANK_AW),
         .IDX_W    (IDX_W),
         .CNT_W    (CNT_W),
         .CELL_NUM (k)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl_in       (ctrl),
         .wr_en         (wr_sel),
         .wr_addr       (wr_idx[BANK_AW-1:0]),
         .wr_identifier (req_entry_identifier),
         .wr_continues  (req_entry_continues),
         .rd_addr       (scan_addr_ff),
         .target        (target_ff),
         .count         (count_ff),
         .up_hit        (up_hit),
         .up_index      (up_index),
         .tok_hit       (chain_hit[k]),
         .tok_index     (chain_index[k])
      );
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_line_index = line_ff;
   assign rsp_found      = found_ff;

   // checks
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response shown while a lookup is still running");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_LOOKUP)) |=> busy)
      else $error("accepted lookup did not raise busy");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |-> (rsp_line_index == '0))
      else $error("miss response carries a nonzero line index");

endmodule

`default_nettype wire

### test/line_start_checker.sv
// ----------------------------------------------------------------------------
// line_start_checker: response predictor and scoreboard for the table search
// Watches the request and response ports of line_start_table_search, keeps
// its own copy of the entry table and entry count, predicts the line index
// of every accepted lookup and compares it with the strobed response.
// ----------------------------------------------------------------------------
`default_nettype none

module line_start_checker #(
   parameter int TABLE_DEPTH = 1024,
   parameter int ID_WIDTH    = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire logic [lst_pkg::CMD_W-1:0]       req_command,
   input  wire logic [lst_pkg::ENTRY_IN_W-1:0]  req_entry_index,
   input  wire logic [ID_WIDTH-1:0]             req_entry_identifier,
   input  wire logic                            req_entry_continues,
   input  wire logic [lst_pkg::COUNT_IN_W-1:0]  req_entry_count,
   input  wire logic [ID_WIDTH-1:0]             req_target_identifier,
   input  wire logic                            rsp_strobe,
   input  wire logic [lst_pkg::LINE_W-1:0]      rsp_line_index,
   input  wire logic                            rsp_found,
   output int                                   fail_count,
   output int                                   pending
);

   localparam int LW = lst_pkg::LINE_W;

   typedef struct packed {
      logic [LW-1:0] line_index;
      logic          found;
   } line_hit_type;

   // shadow copy of the entry table
   logic [ID_WIDTH-1:0]               id_mirror   [TABLE_DEPTH];
   logic                              cont_mirror [TABLE_DEPTH];
   logic [lst_pkg::COUNT_IN_W-1:0]    live_count;
   line_hit_type                      hit_queue [$];

   // greatest valid index below the target, or equal with continuation clear
   function automatic line_hit_type find_line_start(input logic [ID_WIDTH-1:0] target);
      line_hit_type res;
      res = '0;
      for (int pos = int'(live_count) - 1; pos >= 0; pos--) begin
         if (id_mirror[pos] < target ||
             (id_mirror[pos] == target && !cont_mirror[pos])) begin
            res.line_index = LW'(pos);
            res.found      = 1'b1;
            return res;
         end
      end
      return res;
   endfunction

   // sample both channels at the rising edge; response first, then request
   always @(posedge clock) begin
      line_hit_type want;
      if (reset) begin
         live_count = '0;
         hit_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (hit_queue.size() == 0) begin
               $display("%0t: response with none expected, actual line_index %0d found %0b",
                        $time, rsp_line_index, rsp_found);
               fail_count++;
            end else begin
               want = hit_queue.pop_front();
               if (rsp_line_index !== want.line_index) begin
                  $display("%0t: line_index expected %0d actual %0d",
                           $time, want.line_index, rsp_line_index);
                  fail_count++;
               end
               if (rsp_found !== want.found) begin
                  $display("%0t: found expected %0b actual %0b",
                           $time, want.found, rsp_found);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            case (req_command)
               lst_pkg::CMD_WRITE: begin
                  if (int'(req_entry_index) < TABLE_DEPTH) begin
                     id_mirror[req_entry_index]   = req_entry_identifier;
                     cont_mirror[req_entry_index] = req_entry_continues;
                  end
               end
               lst_pkg::CMD_COUNT: begin
                  // counts past the table saturate
                  if (int'(req_entry_count) > TABLE_DEPTH)
                     live_count = lst_pkg::COUNT_IN_W'(TABLE_DEPTH);
                  else
                     live_count = req_entry_count;
               end
               lst_pkg::CMD_LOOKUP: begin
                  hit_queue.push_back(find_line_start(req_target_identifier));
               end
               default: begin
                  // unknown command: no effect, no response
               end
            endcase
         end
      end
      pending = hit_queue.size();
   end

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for line_start_table_search
// Drives write, set-count and lookup requests with random idle gaps, first a
// directed set of corner cases, then one full-depth sorted table and many
// small tables with random content. A separate checker predicts and scores.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int DEPTH     = 1024;
   localparam int ID_W      = 32;
   localparam int ITEMS     = 1800;
   localparam int LIMIT     = 600000;
   localparam int DRAIN     = 80;
   localparam logic [lst_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

   logic                               clock;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic [lst_pkg::CMD_W-1:0]          req_command;
   logic [lst_pkg::ENTRY_IN_W-1:0]     req_entry_index;
   logic [ID_W-1:0]                    req_entry_identifier;
   logic                               req_entry_continues;
   logic [lst_pkg::COUNT_IN_W-1:0]     req_entry_count;
   logic [ID_W-1:0]                    req_target_identifier;
   logic                               rsp_strobe;
   logic [lst_pkg::LINE_W-1:0]         rsp_line_index;
   logic                               rsp_found;
   int                                 fail_count;
   int                                 pending;

   // stimulus-side view of the table, used to aim lookup targets
   logic [ID_W-1:0]                    stim_id [DEPTH];
   int                                 cur_count;
   int                                 sent;
   int                                 cycles;
   bit                                 calm;

   line_start_table_search #(
      .TABLE_DEPTH (DEPTH),
      .ID_WIDTH    (ID_W)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_command           (req_command),
      .req_entry_index       (req_entry_index),
      .req_entry_identifier  (req_entry_identifier),
      .req_entry_continues   (req_entry_continues),
      .req_entry_count       (req_entry_count),
      .req_target_identifier (req_target_identifier),
      .rsp_strobe            (rsp_strobe),
      .rsp_line_index        (rsp_line_index),
      .rsp_found             (rsp_found)
   );

   line_start_checker #(
      .TABLE_DEPTH (DEPTH),
      .ID_WIDTH    (ID_W)
   ) u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_command           (req_command),
      .req_entry_index       (req_entry_index),
      .req_entry_identifier  (req_entry_identifier),
      .req_entry_continues   (req_entry_continues),
      .req_entry_count       (req_entry_count),
      .req_target_identifier (req_target_identifier),
      .rsp_strobe            (rsp_strobe),
      .rsp_line_index        (rsp_line_index),
      .rsp_found             (rsp_found),
      .fail_count            (fail_count),
      .pending               (pending)
   );

   // clock, period 12
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // run watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // idle cycles before a request: mostly none or short, a few long
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // identifier increment for sorted tables; zero gives duplicates
   function automatic logic [32:0] id_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return 33'd0;
      if (r < 80) return 33'($urandom_range(1, 3));
      if (r < 95) return 33'($urandom_range(4, 1000));
      return {1'b0, $urandom()};
   endfunction

   // lookup target near a valid entry, random, or at the extremes
   function automatic logic [ID_W-1:0] pick_target();
      int r;
      logic [ID_W-1:0] base;
      if (cur_count == 0) return $urandom();
      base = stim_id[$urandom_range(0, cur_count - 1)];
      r = $urandom_range(0, 99);
      if (r < 40) return base;
      if (r < 60) return base + 1'b1;
      if (r < 80) return base - 1'b1;
      if (r < 90) return $urandom();
      if (r < 95) return '0;
      return '1;
   endfunction

   // present one request and hold it until accepted
   task automatic issue(input logic [lst_pkg::CMD_W-1:0] cmd,
                        input logic [lst_pkg::ENTRY_IN_W-1:0] idx,
                        input logic [ID_W-1:0] ident,
                        input logic cont,
                        input logic [lst_pkg::COUNT_IN_W-1:0] cnt,
                        input logic [ID_W-1:0] tgt);
      int gap;
      gap = calm ? 0 : idle_cycles();
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start                 <= 1'b1;
      req_command           <= cmd;
      req_entry_index       <= idx;
      req_entry_identifier  <= ident;
      req_entry_continues   <= cont;
      req_entry_count       <= cnt;
      req_target_identifier <= tgt;
      do @(posedge clock); while (busy);
      if (cmd != CMD_NONE) sent++;
      if (cmd == lst_pkg::CMD_WRITE) stim_id[idx] = ident;
      if (cmd == lst_pkg::CMD_COUNT) cur_count = (int'(cnt) > DEPTH) ? DEPTH : int'(cnt);
   endtask

   task automatic write_entry(input int idx, input logic [ID_W-1:0] ident, input logic cont);
      issue(lst_pkg::CMD_WRITE, lst_pkg::ENTRY_IN_W'(idx), ident, cont,
            lst_pkg::COUNT_IN_W'($urandom()), $urandom());
   endtask

   task automatic set_count(input int cnt);
      issue(lst_pkg::CMD_COUNT, lst_pkg::ENTRY_IN_W'($urandom()), $urandom(),
            1'($urandom()), lst_pkg::COUNT_IN_W'(cnt), $urandom());
   endtask

   task automatic look_up(input logic [ID_W-1:0] tgt);
      issue(lst_pkg::CMD_LOOKUP, lst_pkg::ENTRY_IN_W'($urandom()), $urandom(),
            1'($urandom()), lst_pkg::COUNT_IN_W'($urandom()), tgt);
   endtask

   // unknown command with random fields
   task automatic stray_request();
      issue(CMD_NONE, lst_pkg::ENTRY_IN_W'($urandom()), $urandom(), 1'($urandom()),
            lst_pkg::COUNT_IN_W'($urandom()), $urandom());
   endtask

   // write n entries from lo upward in non-decreasing identifier order
   task automatic fill_sorted(input int lo, input int n);
      logic [32:0] acc;
      acc = {1'b0, $urandom()} >> $urandom_range(0, 32);
      for (int i = 0; i < n; i++) begin
         write_entry(lo + i, acc[ID_W-1:0], 1'($urandom()));
         acc = acc + id_step();
         if (acc[32]) acc = 33'h0_ffff_ffff;
      end
   endtask

   initial begin
      int n;
      int k;
      int r;
      logic [ID_W-1:0] pool;
      reset                 = 1'b1;
      start                 = 1'b0;
      req_command           = lst_pkg::CMD_WRITE;
      req_entry_index       = '0;
      req_entry_identifier  = '0;
      req_entry_continues   = 1'b0;
      req_entry_count       = '0;
      req_target_identifier = '0;
      cur_count             = 0;
      sent                  = 0;
      cycles                = 0;
      calm                  = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty table
      look_up('0);
      look_up('1);
      // small table with a duplicate identifier and a top identifier
      write_entry(0, 32'd5, 1'b0);
      write_entry(1, 32'd5, 1'b1);
      write_entry(2, 32'd9, 1'b1);
      write_entry(3, 32'hffff_ffff, 1'b0);
      set_count(4);
      look_up(32'd0);           // below every entry
      look_up(32'd4);
      look_up(32'd5);           // equal, continuation set on the later one
      look_up(32'd6);
      look_up(32'd9);           // equal with continuation set
      look_up(32'd10);
      look_up(32'hffff_fffe);
      look_up(32'hffff_ffff);   // equal at the top entry
      stray_request();
      set_count(1);
      look_up(32'd5);
      look_up(32'd4);
      set_count(0);
      look_up(32'd7);
      // unsorted table
      write_entry(1, 32'd0, 1'b0);
      set_count(4);
      look_up(32'd3);
      look_up(32'd0);

      // full-depth sorted table, then counts at and past the end
      calm = ($urandom_range(0, 3) == 0);
      fill_sorted(0, DEPTH);
      set_count(DEPTH);
      for (int i = 0; i < 30; i++) begin
         calm = ($urandom_range(0, 7) == 0);
         look_up(pick_target());
      end
      look_up('0);
      look_up('1);
      look_up(stim_id[0]);
      look_up(stim_id[DEPTH-1]);
      set_count(2047);
      look_up(pick_target());
      look_up('1);
      set_count(DEPTH + 1);
      look_up(pick_target());
      for (int i = 0; i < 5; i++) begin
         set_count($urandom_range(1, DEPTH));
         look_up(pick_target());
         look_up(pick_target());
      end

      // small tables: mostly well-formed build-then-search sequences
      while (sent < ITEMS) begin
         calm = ($urandom_range(0, 4) == 0);
         n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 24);
         r = $urandom_range(0, 99);
         if (r < 80) begin
            fill_sorted(0, n);
         end else begin
            // unsorted, identifiers from a narrow pool to force ties
            pool = $urandom();
            for (int i = 0; i < n; i++)
               write_entry(i, pool + ID_W'($urandom_range(0, 7)), 1'($urandom()));
         end
         r = $urandom_range(0, 99);
         if (r < 75) set_count(n);
         else if (r < 90) set_count($urandom_range(0, DEPTH));
         else set_count(DEPTH);
         k = $urandom_range(1, 6);
         for (int i = 0; i < k; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) stray_request();
            else if (r < 14) set_count($urandom_range(0, DEPTH));
            else if (r < 18) write_entry($urandom_range(0, DEPTH - 1), $urandom(),
                                         1'($urandom()));
            look_up(pick_target());
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
